### src/wsd_pkg.sv
// Package with the shared types and constants of the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   localparam logic [3:0] OPC_TEXT       = 4'd1;
   localparam logic [3:0] OPC_BINARY     = 4'd2;
   localparam logic [6:0] LEN_EXT16      = 7'd126;
   localparam logic [6:0] LEN_EXT64      = 7'd127;
   localparam logic [3:0] EXT16_BYTES    = 4'd2;
   localparam logic [3:0] EXT64_BYTES    = 4'd8;
   localparam logic [1:0] KEY_LAST       = 2'd3;
   localparam logic       STRICT_DEFAULT = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       fin_bit;
      logic [2:0] rsv_bits;
      logic [3:0] frame_opcode;
      logic       was_masked;
      logic       last_of_frame;
      logic       empty_frame;
      logic       opcode_error;
   } rsp_payload_type;

endpackage
`default_nettype wire

### src/wsd_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
`default_nettype none
interface wsd_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface
`default_nettype wire

### src/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer: input register, parser and result register.
//
//   Channel   Direction  Transaction
//   req       in         one raw byte of the frame stream
//   rsp       out        one payload byte, empty-frame marker or opcode error
//   csr       in         write of the strict opcode check bit
//
// One byte is taken every cycle unless a stalled result register holds it; its result, if any, is registered.
// The rate is set by the parser step between the input and result registers.
// Reset is synchronous; it restores the header wait and turns strict mode on.
// A stalled result register holds the input register, which then holds req.
`default_nettype none
module websocket_frame_deframer_top (
   input  wire logic   clock,
   input  wire logic   reset,
   wsd_stream_if.sink  req_chan,
   wsd_stream_if.source rsp_chan,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data
);
   import wsd_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff;
   logic            advance;
   logic            res_valid;
   rsp_payload_type res_data;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = res_valid;
      end else begin
         out_valid_in = out_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.payload.in_byte;
      end
      if (advance && res_valid) begin
         out_data_ff <= res_data;
      end
   end

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .byte_in     (in_byte_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule
`default_nettype wire

### src/wsd_parser.sv
// Frame parser state and the per-byte decode that forms one result.
`default_nettype none
module wsd_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               byte_in,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data,
   output logic                          res_valid,
   output wsd_pkg::rsp_payload_type      res_data
);
   import wsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  len_cnt_ff, len_cnt_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_pos_ff, key_pos_in;
   logic [8:0]  flags_ff, flags_in;
   logic        discard_ff, discard_in;
   logic        strict_ff;

   logic        len_end;
   logic        hdr_end;
   logic [7:0]  key_byte;
   logic [7:0]  data;
   logic        last;
   logic        empty;
   logic        err;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= STRICT_DEFAULT;
      end else if (csr_wr_en) begin
         strict_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR0;
         len_cnt_ff <= '0;
         remain_ff  <= '0;
         key_ff     <= '0;
         key_pos_ff <= '0;
         flags_ff   <= '0;
         discard_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         len_cnt_ff <= len_cnt_in;
         remain_ff  <= remain_in;
         key_ff     <= key_in;
         key_pos_ff <= key_pos_in;
         flags_ff   <= flags_in;
         discard_ff <= discard_in;
      end
   end

   always_comb begin
      unique case (key_pos_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         2'd3: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      len_cnt_in = len_cnt_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      key_pos_in = key_pos_ff;
      flags_in   = flags_ff;
      discard_in = discard_ff;
      len_end    = 1'b0;
      hdr_end    = 1'b0;
      res_valid  = 1'b0;
      data       = 8'd0;
      last       = 1'b0;
      empty      = 1'b0;
      err        = 1'b0;

      unique case (phase_ff)
         PH_HDR1: begin
            flags_in  = {byte_in[7], flags_ff[7:0]};
            remain_in = '0;
            if (byte_in[6:0] == LEN_EXT16) begin
               len_cnt_in = EXT16_BYTES;
               phase_in   = PH_EXTLEN;
            end else if (byte_in[6:0] == LEN_EXT64) begin
               len_cnt_in = EXT64_BYTES;
               phase_in   = PH_EXTLEN;
            end else begin
               remain_in = {57'd0, byte_in[6:0]};
               len_end   = 1'b1;
            end
         end
         PH_EXTLEN: begin
            remain_in  = {remain_ff[55:0], byte_in};
            len_cnt_in = len_cnt_ff - 4'd1;
            len_end    = (len_cnt_in == 4'd0);
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], byte_in};
            if (key_pos_ff == KEY_LAST) begin
               hdr_end = 1'b1;
            end else begin
               key_pos_in = key_pos_ff + 2'd1;
            end
         end
         PH_PAYLOAD: begin
            remain_in = remain_ff - 64'd1;
            if (remain_in == 64'd0) begin
               phase_in = PH_HDR0;
            end
            if (!discard_ff) begin
               key_pos_in = key_pos_ff + 2'd1;
               res_valid  = 1'b1;
               data       = flags_ff[8] ? (byte_in ^ key_byte) : byte_in;
               last       = (remain_in == 64'd0);
            end
         end
         default: begin
            flags_in   = {1'b0, byte_in};
            discard_in = strict_ff && (byte_in[3:0] != OPC_TEXT)
                         && (byte_in[3:0] != OPC_BINARY);
            len_cnt_in = '0;
            remain_in  = '0;
            key_pos_in = '0;
            phase_in   = PH_HDR1;
         end
      endcase

      if (len_end) begin
         if (flags_in[8]) begin
            key_in     = '0;
            key_pos_in = '0;
            phase_in   = PH_KEY;
         end else begin
            hdr_end = 1'b1;
         end
      end

      if (hdr_end) begin
         key_pos_in = '0;
         if (discard_ff) begin
            res_valid = 1'b1;
            last      = 1'b1;
            err       = 1'b1;
            phase_in  = (remain_in != 64'd0) ? PH_PAYLOAD : PH_HDR0;
         end else if (remain_in == 64'd0) begin
            res_valid = 1'b1;
            last      = 1'b1;
            empty     = 1'b1;
            phase_in  = PH_HDR0;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end

      res_data.data_byte     = data;
      res_data.fin_bit       = flags_in[7];
      res_data.rsv_bits      = flags_in[6:4];
      res_data.frame_opcode  = flags_in[3:0];
      res_data.was_masked    = flags_in[8];
      res_data.last_of_frame = last;
      res_data.empty_frame   = empty;
      res_data.opcode_error  = err;
   end

endmodule
`default_nettype wire

### tb/websocket_frame_deframer_top_tb.sv
// Testbench for the WebSocket frame deframer: byte stream stimulus, prediction and check.
`timescale 1ns / 100ps
module websocket_frame_deframer_top_tb;
   import wsd_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 75;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int MAX_PRINTS   = 20;

   localparam logic [3:0] OPC_CONT       = 4'h0;
   localparam logic [3:0] OPC_CLOSE      = 4'h8;
   localparam logic [3:0] OPC_PONG       = 4'hA;
   localparam logic [3:0] OPC_RESERVED_F = 4'hF;

   typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   wsd_stream_if #(.payload_type(req_payload_type)) req_chan ();
   wsd_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   websocket_frame_deframer_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Parser state mirrored from the stream that the block has accepted.
   phase_type   frame_phase;
   logic [3:0]  ext_len_left;
   logic [63:0] payload_left;
   logic [31:0] mask_key;
   logic [1:0]  mask_pos;
   logic [8:0]  hdr_flags;
   logic        drop_payload;
   logic        strict_mode;

   logic [7:0]      wire_bytes[$];
   rsp_payload_type awaited_rsp[$];

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int fail_count = 0;
   int bytes_queued = 0;
   int bytes_accepted = 0;
   int frames_sent = 0;
   int data_results = 0;
   int empty_results = 0;
   int error_results = 0;

   function automatic rsp_payload_type make_rsp(input logic [7:0] data, input logic last,
                                                input logic empty, input logic err);
      rsp_payload_type r;
      r.data_byte     = data;
      r.fin_bit       = hdr_flags[7];
      r.rsv_bits      = hdr_flags[6:4];
      r.frame_opcode  = hdr_flags[3:0];
      r.was_masked    = hdr_flags[8];
      r.last_of_frame = last;
      r.empty_frame   = empty;
      r.opcode_error  = err;
      return r;
   endfunction

   function automatic bit finish_header(output rsp_payload_type r);
      mask_pos = 2'd0;
      if (drop_payload) begin
         r = make_rsp(8'h00, 1'b1, 1'b0, 1'b1);
         frame_phase = (payload_left != 64'd0) ? PH_PAYLOAD : PH_HDR0;
         return 1'b1;
      end
      if (payload_left == 64'd0) begin
         r = make_rsp(8'h00, 1'b1, 1'b1, 1'b0);
         frame_phase = PH_HDR0;
         return 1'b1;
      end
      frame_phase = PH_PAYLOAD;
      return 1'b0;
   endfunction

   function automatic bit finish_length(output rsp_payload_type r);
      if (hdr_flags[8]) begin
         mask_key = 32'd0;
         mask_pos = 2'd0;
         frame_phase = PH_KEY;
         return 1'b0;
      end
      return finish_header(r);
   endfunction

   // Advances the mirrored parser by one stream byte; returns 1 when a result is due.
   function automatic bit parse_byte(input logic [7:0] b, output rsp_payload_type r);
      logic [7:0] kb;
      r = '0;
      case (frame_phase)
         PH_HDR1: begin
            hdr_flags = {b[7], hdr_flags[7:0]};
            payload_left = 64'd0;
            if (b[6:0] == LEN_EXT16) begin
               ext_len_left = EXT16_BYTES;
               frame_phase = PH_EXTLEN;
               return 1'b0;
            end
            if (b[6:0] == LEN_EXT64) begin
               ext_len_left = EXT64_BYTES;
               frame_phase = PH_EXTLEN;
               return 1'b0;
            end
            payload_left = {57'd0, b[6:0]};
            return finish_length(r);
         end
         PH_EXTLEN: begin
            payload_left = {payload_left[55:0], b};
            ext_len_left = ext_len_left - 4'd1;
            if (ext_len_left != 4'd0) return 1'b0;
            return finish_length(r);
         end
         PH_KEY: begin
            mask_key = {mask_key[23:0], b};
            if (mask_pos == KEY_LAST) return finish_header(r);
            mask_pos = mask_pos + 2'd1;
            return 1'b0;
         end
         PH_PAYLOAD: begin
            payload_left = payload_left - 64'd1;
            if (payload_left == 64'd0) frame_phase = PH_HDR0;
            if (drop_payload) return 1'b0;
            kb = hdr_flags[8] ? mask_key[8 * (3 - mask_pos) +: 8] : 8'h00;
            mask_pos = mask_pos + 2'd1;
            r = make_rsp(b ^ kb, payload_left == 64'd0, 1'b0, 1'b0);
            return 1'b1;
         end
         default: begin
            hdr_flags = {1'b0, b};
            drop_payload = strict_mode && b[3:0] != OPC_TEXT && b[3:0] != OPC_BINARY;
            ext_len_left = 4'd0;
            payload_left = 64'd0;
            mask_pos = 2'd0;
            frame_phase = PH_HDR1;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_PRINTS) $display("ERROR %0t: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin : req_driver
      rsp_payload_type r;
      logic offer;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (parse_byte(req_chan.payload.in_byte, r)) awaited_rsp.insert(awaited_rsp.size(), r);
            void'(wire_bytes.pop_front());
            bytes_accepted++;
         end
         offer = wire_bytes.size() != 0 &&
                 ((req_chan.valid && !req_chan.ready) || $urandom_range(0, 99) >= req_idle_pct);
         req_chan.valid <= offer;
         if (offer) req_chan.payload.in_byte <= wire_bytes[0];
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (awaited_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected result transaction 0x%0h", got));
            end else begin
               want = awaited_rsp.pop_front();
               check_field("data_byte", got.data_byte, want.data_byte);
               check_field("fin_bit", got.fin_bit, want.fin_bit);
               check_field("rsv_bits", got.rsv_bits, want.rsv_bits);
               check_field("frame_opcode", got.frame_opcode, want.frame_opcode);
               check_field("was_masked", got.was_masked, want.was_masked);
               check_field("last_of_frame", got.last_of_frame, want.last_of_frame);
               check_field("empty_frame", got.empty_frame, want.empty_frame);
               check_field("opcode_error", got.opcode_error, want.opcode_error);
               if (want.opcode_error) error_results++;
               else if (want.empty_frame) empty_results++;
               else data_results++;
            end
         end
         rsp_chan.ready <= hold_left == 0 && $urandom_range(0, 99) >= rsp_stall_pct;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
         $display("websocket_frame_deframer_top test failed");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      wire_bytes.insert(wire_bytes.size(), b);
      bytes_queued++;
   endtask

   task automatic queue_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
                              input logic masked, input len_form_type form,
                              input logic [63:0] len, input int unsigned body);
      logic [31:0] key;
      key = $urandom;
      push_byte({fin, rsv, opc});
      case (form)
         FORM_EXT16: begin
            push_byte({masked, LEN_EXT16});
            for (int i = 1; i >= 0; i--) push_byte(len[8 * i +: 8]);
         end
         FORM_EXT64: begin
            push_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
         end
         default: begin
            push_byte({masked, len[6:0]});
         end
      endcase
      if (masked) begin
         for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
      end
      repeat (body) push_byte(8'($urandom_range(0, 255)));
      frames_sent++;
   endtask

   task automatic random_frame();
      int unsigned pick;
      int unsigned len;
      logic [31:0] rnd;
      logic [3:0]  opc;
      logic [2:0]  rsv;
      pick = $urandom_range(0, 99);
      rnd = $urandom;
      opc = ($urandom_range(0, 9) < 7) ? ($urandom_range(0, 1) ? OPC_TEXT : OPC_BINARY)
                                       : rnd[3:0];
      rsv = ($urandom_range(0, 4) == 0) ? rnd[6:4] : 3'b000;
      if (pick < 60) begin
         len = $urandom_range(0, 12);
         queue_frame(rnd[8], rsv, opc, rnd[9], FORM_SHORT, 64'(len), len);
      end else if (pick < 70) begin
         len = $urandom_range(0, 125);
         queue_frame(rnd[8], rsv, opc, rnd[9], FORM_SHORT, 64'(len), len);
      end else if (pick < 82) begin
         len = $urandom_range(0, 40);
         queue_frame(rnd[8], rsv, opc, rnd[9], FORM_EXT16, 64'(len), len);
      end else if (pick < 85) begin
         len = $urandom_range(126, 300);
         queue_frame(rnd[8], rsv, opc, rnd[9], FORM_EXT16, 64'(len), len);
      end else if (pick < 93) begin
         len = $urandom_range(0, 20);
         queue_frame(rnd[8], rsv, opc, rnd[9], FORM_EXT64, 64'(len), len);
      end else begin
         // Fully random header bits with a short payload.
         len = $urandom_range(0, 125);
         queue_frame(rnd[8], rnd[6:4], rnd[3:0], rnd[9], FORM_SHORT, 64'(len), len);
      end
   endtask

   task automatic wait_idle();
      while (wire_bytes.size() != 0 || awaited_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_strict(input logic v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      strict_mode = v;
      @(negedge clock);
   endtask

   task automatic run_random(input logic strict, input int idle, input int stall,
                             input int hold, input bit huge_tail);
      int start;
      write_strict(strict);
      req_idle_pct = idle;
      rsp_stall_pct = stall;
      hold_left = hold;
      start = bytes_queued;
      while (bytes_queued - start < PHASE_BYTES) random_frame();
      // A length with its top bit set can never complete, so it closes the run.
      if (huge_tail) queue_frame(1'b1, 3'b000, OPC_BINARY, 1'b1, FORM_EXT64,
                                 64'h8000_0000_0000_0040, 6);
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      frame_phase = PH_HDR0;
      ext_len_left = 4'd0;
      payload_left = 64'd0;
      mask_key = 32'd0;
      mask_pos = 2'd0;
      hdr_flags = 9'd0;
      drop_payload = 1'b0;
      strict_mode = STRICT_DEFAULT;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames with the reset value of strict mode.
      queue_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, FORM_SHORT, 64'd1, 1);
      queue_frame(1'b1, 3'b000, OPC_BINARY, 1'b1, FORM_SHORT, 64'd5, 5);
      queue_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, FORM_SHORT, 64'd0, 0);
      queue_frame(1'b0, 3'b000, OPC_BINARY, 1'b1, FORM_SHORT, 64'd0, 0);
      queue_frame(1'b1, 3'b000, OPC_CLOSE, 1'b1, FORM_SHORT, 64'd2, 2);
      queue_frame(1'b0, 3'b111, OPC_TEXT, 1'b0, FORM_EXT16, 64'd1, 1);
      queue_frame(1'b1, 3'b000, OPC_TEXT, 1'b0, FORM_EXT64, 64'd0, 0);
      push_byte({1'b1, 3'b000, OPC_PONG});
      wait_idle();
      // The pong header was seen in strict mode, so it stays rejected after the write.
      write_strict(1'b0);
      push_byte({1'b0, 7'd1});
      push_byte(8'hFF);
      frames_sent++;
      queue_frame(1'b1, 3'b000, OPC_CLOSE, 1'b0, FORM_SHORT, 64'd1, 1);
      queue_frame(1'b0, 3'b000, OPC_RESERVED_F, 1'b1, FORM_SHORT, 64'd2, 2);
      queue_frame(1'b1, 3'b000, OPC_CONT, 1'b0, FORM_SHORT, 64'd1, 1);
      wait_idle();

      run_random(1'b1, 0, 0, HOLD_CYCLES, 1'b0);
      run_random(1'b0, 49, 0, 0, 1'b0);
      run_random(1'b1, 0, 49, 0, 1'b0);
      run_random(1'b0, 8, 8, 0, 1'b1);

      $display("Sent %0d frames in %0d bytes, strict mode on and off, four flow-control mixes.",
               frames_sent, bytes_accepted);
      $display("Checked %0d payload bytes, %0d empty frames and %0d opcode errors.",
               data_results, empty_results, error_results);
      if (fail_count == 0) begin
         $display("websocket_frame_deframer_top test passed");
      end else begin
         $display("websocket_frame_deframer_top test failed");
      end
      $finish;
   end

endmodule
